>>> sv/bjcs_pkg.sv
// Shared types, constants and jingle tables for the buzzer sequencer.
package bjcs_pkg;

  typedef enum logic [1:0] {
    MODE_TICK  = 2'd0,
    MODE_EVENT = 2'd1,
    MODE_PROX  = 2'd2,
    MODE_NONE  = 2'd3
  } mode_t;

  localparam logic [2:0]  EV_SILENT    = 3'd7;
  localparam logic [15:0] DEFAULT_FREQ = 16'd2200;

  localparam logic [15:0] HZ_E6  = 16'd1319;
  localparam logic [15:0] HZ_G6  = 16'd1568;
  localparam logic [15:0] HZ_A6  = 16'd1760;
  localparam logic [15:0] HZ_B6  = 16'd1976;
  localparam logic [15:0] HZ_C7  = 16'd2093;
  localparam logic [15:0] HZ_CS7 = 16'd2217;
  localparam logic [15:0] HZ_E7  = 16'd2637;

  typedef struct packed {
    logic       enq;
    logic       pop;
    logic       flush;
    logic [2:0] code;
  } qreq_t;

  typedef struct packed {
    logic       full;
    logic       any;
    logic       front_valid;
    logic [2:0] front_code;
  } qstat_t;

  typedef struct packed {
    logic        event_dropped;
    logic        jingle_busy;
    logic [15:0] tone_hz;
    logic        tone_active;
  } res_t;

  function automatic logic [2:0] step_total(input logic [2:0] code);
    logic [2:0] n;
    case (code)
      3'd1:    n = 3'd1;
      3'd5:    n = 3'd5;
      3'd7:    n = 3'd0;
      default: n = 3'd3;
    endcase
    return n;
  endfunction

  function automatic logic [15:0] step_hz(input logic [2:0] code, input logic [2:0] step);
    logic [15:0] hz;
    hz = '0;
    case ({code, step})
      {3'd0, 3'd0}: hz = HZ_G6;
      {3'd0, 3'd2}: hz = HZ_C7;
      {3'd1, 3'd0}: hz = HZ_C7;
      {3'd2, 3'd0}: hz = HZ_C7;
      {3'd2, 3'd2}: hz = HZ_C7;
      {3'd3, 3'd0}: hz = HZ_E6;
      {3'd3, 3'd2}: hz = HZ_A6;
      {3'd4, 3'd0}: hz = HZ_A6;
      {3'd4, 3'd2}: hz = HZ_E6;
      {3'd5, 3'd0}: hz = HZ_A6;
      {3'd5, 3'd2}: hz = HZ_CS7;
      {3'd5, 3'd4}: hz = HZ_E7;
      {3'd6, 3'd0}: hz = HZ_B6;
      {3'd6, 3'd2}: hz = HZ_E6;
      default:      hz = '0;
    endcase
    return hz;
  endfunction

  function automatic logic [6:0] step_ms(input logic [2:0] code, input logic [2:0] step);
    logic [6:0] ms;
    ms = '0;
    case ({code, step})
      {3'd0, 3'd0}: ms = 7'd60;
      {3'd0, 3'd1}: ms = 7'd40;
      {3'd0, 3'd2}: ms = 7'd100;
      {3'd1, 3'd0}: ms = 7'd25;
      {3'd2, 3'd0}: ms = 7'd25;
      {3'd2, 3'd1}: ms = 7'd35;
      {3'd2, 3'd2}: ms = 7'd25;
      {3'd3, 3'd0}: ms = 7'd50;
      {3'd3, 3'd1}: ms = 7'd25;
      {3'd3, 3'd2}: ms = 7'd70;
      {3'd4, 3'd0}: ms = 7'd50;
      {3'd4, 3'd1}: ms = 7'd25;
      {3'd4, 3'd2}: ms = 7'd70;
      {3'd5, 3'd0}: ms = 7'd45;
      {3'd5, 3'd1}: ms = 7'd20;
      {3'd5, 3'd2}: ms = 7'd45;
      {3'd5, 3'd3}: ms = 7'd20;
      {3'd5, 3'd4}: ms = 7'd80;
      {3'd6, 3'd0}: ms = 7'd60;
      {3'd6, 3'd1}: ms = 7'd25;
      {3'd6, 3'd2}: ms = 7'd90;
      default:      ms = '0;
    endcase
    return ms;
  endfunction

endpackage

>>> sv/buzzer_jingle_and_cadence_sequencer.sv
// Top level of the buzzer jingle and proximity cadence sequencer.
//
//   channel  | signals                      | carries
//   ---------+------------------------------+-------------------------------
//   s_       | s_tvalid s_tready s_tdata    | input item, mode in s_tuser
//   m_       | m_tvalid m_tready m_tdata    | result item per input item
//   cfg_     | cfg_valid cfg_ready cfg_data | sound enable register
//
// One item per cycle while s_tready is high; its result is registered in the skid (q0, or q1 if m_ stalls).
// Tick handling, queue pop and cadence settle in one pass of logic.
// rst resets all control state; the queue memory needs no clearing pass.
// A stalled m_ side fills the skid slot, then drops s_tready.
module buzzer_jingle_and_cadence_sequencer import bjcs_pkg::*; #(
  parameter int QUEUE_DEPTH    = 8,
  parameter int BEEP_LENGTH_MS = 45
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // event_code, beep_interval_ms, beep_freq_hz, zero fill
  input  logic [1:0]  s_tuser,   // mode
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // tone_active, tone_hz, jingle_busy, event_dropped, zero fill
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_data
);

  logic   accept;
  qreq_t  qreq;
  qstat_t qstat;
  res_t   res, out_res;

  assign accept    = s_tvalid && s_tready;
  assign cfg_ready = 1'b1;

  bjcs_queue #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk  (clk),
    .rst  (rst),
    .req  (qreq),
    .stat (qstat)
  );

  bjcs_core #(
    .BEEP_LENGTH_MS(BEEP_LENGTH_MS)
  ) u_core (
    .clk              (clk),
    .rst              (rst),
    .accept           (accept),
    .mode             (mode_t'(s_tuser)),
    .event_code       (s_tdata[2:0]),
    .beep_interval_ms (s_tdata[19:3]),
    .beep_freq_hz     (s_tdata[35:20]),
    .cfg_we           (cfg_valid && cfg_ready),
    .cfg_data         (cfg_data),
    .qstat            (qstat),
    .qreq             (qreq),
    .res              (res)
  );

  bjcs_skid u_skid (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_data   (res),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (out_res)
  );

  assign m_tdata = {5'd0, out_res};

endmodule

>>> sv/bjcs_queue.sv
// Event queue: playable events in memory, silent codes kept as counts.
module bjcs_queue import bjcs_pkg::*; #(
  parameter int QUEUE_DEPTH = 8
) (
  input  logic   clk,
  input  logic   rst,
  input  qreq_t  req,
  output qstat_t stat
);

  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam logic [AW-1:0] LAST = AW'(QUEUE_DEPTH - 1);
  localparam logic [CW-1:0] FULL = CW'(QUEUE_DEPTH);

  typedef struct packed {
    logic [CW-1:0] pre;
    logic [2:0]    code;
  } entry_t;

  entry_t        mem [QUEUE_DEPTH];
  entry_t        rd_q;
  logic [CW-1:0] cnt, cnt_next;
  logic [CW-1:0] rcnt, rcnt_next;
  logic [CW-1:0] tail, tail_next;
  logic [AW-1:0] head, head_next;
  logic [AW-1:0] wptr, wptr_next;
  logic          wr_en;
  entry_t        wr_data;

  always_comb begin
    cnt_next  = cnt;
    rcnt_next = rcnt;
    tail_next = tail;
    head_next = head;
    wptr_next = wptr;
    wr_en     = 1'b0;
    wr_data   = '{pre: tail, code: req.code};
    if (req.enq) begin
      cnt_next = cnt + CW'(1);
      if (req.code == EV_SILENT) begin
        tail_next = tail + CW'(1);
      end else begin
        wr_en     = 1'b1;
        tail_next = '0;
        rcnt_next = rcnt + CW'(1);
        wptr_next = (wptr == LAST) ? '0 : wptr + AW'(1);
      end
    end else if (req.flush) begin
      cnt_next  = '0;
      rcnt_next = '0;
      tail_next = '0;
      head_next = wptr;
    end else if (req.pop) begin
      cnt_next  = cnt - rd_q.pre - CW'(1);
      rcnt_next = rcnt - CW'(1);
      head_next = (head == LAST) ? '0 : head + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wptr] <= wr_data;
    end
    if (wr_en && (wptr == head_next)) begin
      rd_q <= wr_data;
    end else begin
      rd_q <= mem[head_next];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      rcnt <= '0;
      tail <= '0;
      head <= '0;
      wptr <= '0;
    end else begin
      cnt  <= cnt_next;
      rcnt <= rcnt_next;
      tail <= tail_next;
      head <= head_next;
      wptr <= wptr_next;
    end
  end

  assign stat.full        = (cnt == FULL);
  assign stat.any         = (cnt != '0);
  assign stat.front_valid = (rcnt != '0);
  assign stat.front_code  = rd_q.code;

endmodule

>>> sv/bjcs_core.sv
// Jingle player, proximity cadence and tone state, one item per cycle while accept is high.
module bjcs_core import bjcs_pkg::*; #(
  parameter int BEEP_LENGTH_MS = 45
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               accept,
  input  mode_t              mode,
  input  logic [2:0]         event_code,
  input  logic signed [16:0] beep_interval_ms,
  input  logic [15:0]        beep_freq_hz,
  input  logic               cfg_we,
  input  logic               cfg_data,
  input  qstat_t             qstat,
  output qreq_t              qreq,
  output res_t               res
);

  localparam int BW = $clog2(BEEP_LENGTH_MS + 1);

  logic               enable;
  logic               jp, jp_next;
  logic [2:0]         jev, jev_next;
  logic [2:0]         jstep, jstep_next;
  logic [6:0]         sml, sml_next, sml_dec;
  logic [2:0]         step_inc;
  logic               prox, prox_next;
  logic [BW-1:0]      bl, bl_next;
  logic [15:0]        nb, nb_next;
  logic signed [16:0] pint, pint_next;
  logic [15:0]        pfreq, pfreq_next;
  logic [15:0]        cur, cur_next;
  logic               do_pop, run_cad, dropped, active;
  qreq_t              req;

  always_comb begin
    jp_next    = jp;
    jev_next   = jev;
    jstep_next = jstep;
    sml_next   = sml;
    prox_next  = prox;
    bl_next    = bl;
    nb_next    = nb;
    pint_next  = pint;
    pfreq_next = pfreq;
    cur_next   = cur;
    sml_dec    = (sml != '0) ? sml - 7'd1 : '0;
    step_inc   = jstep + 3'd1;
    do_pop     = 1'b0;
    run_cad    = 1'b0;
    dropped    = 1'b0;
    req        = '{enq: 1'b0, pop: 1'b0, flush: 1'b0, code: event_code};
    case (mode)
      MODE_TICK: begin
        do_pop = 1'b1;
        if (jp) begin
          do_pop = 1'b0;
          if (sml_dec != '0) begin
            sml_next = sml_dec;
          end else if (step_inc < step_total(jev)) begin
            jstep_next = step_inc;
            sml_next   = step_ms(jev, step_inc);
            if (step_hz(jev, step_inc) != '0) begin
              cur_next = step_hz(jev, step_inc);
            end
          end else begin
            do_pop     = 1'b1;
            sml_next   = '0;
            jp_next    = 1'b0;
            jstep_next = '0;
            prox_next  = 1'b0;
            nb_next    = '0;
          end
        end
        if (do_pop) begin
          run_cad = 1'b1;
          if (qstat.any) begin
            prox_next = 1'b0;
            nb_next   = '0;
            if (enable && qstat.front_valid) begin
              req.pop    = 1'b1;
              run_cad    = 1'b0;
              jp_next    = 1'b1;
              jev_next   = qstat.front_code;
              jstep_next = '0;
              sml_next   = step_ms(qstat.front_code, 3'd0);
              if (step_hz(qstat.front_code, 3'd0) != '0) begin
                cur_next = step_hz(qstat.front_code, 3'd0);
              end
            end else begin
              req.flush = 1'b1;
            end
          end
        end
        if (run_cad) begin
          bl_next = (bl != '0) ? bl - BW'(1) : '0;
          if (nb_next != '0) begin
            nb_next = nb_next - 16'd1;
          end
          if (!enable || pint[16]) begin
            prox_next = 1'b0;
          end else if (pint == '0) begin
            if (!prox_next) begin
              prox_next = 1'b1;
              cur_next  = pfreq;
            end
          end else begin
            if (prox_next && (bl_next == '0)) begin
              prox_next = 1'b0;
            end
            if (!prox_next && (nb_next == '0)) begin
              prox_next = 1'b1;
              cur_next  = pfreq;
              bl_next   = BW'(BEEP_LENGTH_MS);
              nb_next   = pint[15:0];
            end
          end
        end
      end
      MODE_EVENT: begin
        req.enq = !qstat.full;
        dropped = qstat.full;
      end
      MODE_PROX: begin
        if (beep_freq_hz != '0) begin
          pfreq_next = beep_freq_hz;
        end
        pint_next = beep_interval_ms;
      end
      default: begin
      end
    endcase
    active = jp_next ? (step_hz(jev_next, jstep_next) != '0) : prox_next;
  end

  assign qreq.enq   = req.enq && accept;
  assign qreq.pop   = req.pop && accept;
  assign qreq.flush = req.flush && accept;
  assign qreq.code  = req.code;

  assign res.tone_active   = active;
  assign res.tone_hz       = active ? cur_next : '0;
  assign res.jingle_busy   = jp_next;
  assign res.event_dropped = dropped;

  always_ff @(posedge clk) begin
    if (rst) begin
      enable <= 1'b1;
      jp     <= 1'b0;
      jev    <= '0;
      jstep  <= '0;
      sml    <= '0;
      prox   <= 1'b0;
      bl     <= '0;
      nb     <= '0;
      pint   <= -17'sd1;
      pfreq  <= DEFAULT_FREQ;
      cur    <= '0;
    end else begin
      if (cfg_we) begin
        enable <= cfg_data;
      end
      if (accept) begin
        jp    <= jp_next;
        jev   <= jev_next;
        jstep <= jstep_next;
        sml   <= sml_next;
        prox  <= prox_next;
        bl    <= bl_next;
        nb    <= nb_next;
        pint  <= pint_next;
        pfreq <= pfreq_next;
        cur   <= cur_next;
      end
    end
  end

endmodule

>>> sv/bjcs_skid.sv
// Two-entry output register with skid slot for the result stream.
module bjcs_skid import bjcs_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  res_t in_data,
  output logic out_valid,
  input  logic out_ready,
  output res_t out_data
);

  logic q0v, q1v;
  res_t q0, q1;

  assign in_ready  = !q1v;
  assign out_valid = q0v;
  assign out_data  = q0;

  always_ff @(posedge clk) begin
    if (rst) begin
      q0v <= 1'b0;
      q1v <= 1'b0;
    end else if (!q0v || out_ready) begin
      if (q1v) begin
        q0  <= q1;
        q1v <= 1'b0;
      end else begin
        q0v <= in_valid;
        q0  <= in_data;
      end
    end else if (in_valid && !q1v) begin
      q1  <= in_data;
      q1v <= 1'b1;
    end
  end

endmodule

>>> test/tb_top.sv
// Self-checking testbench for the buzzer jingle and proximity cadence sequencer.
`timescale 1ns / 100ps

module tb_top;
  import bjcs_pkg::*;

  localparam int   PHASES      = 5;
  localparam int   PHASE_ITEMS = 90;
  localparam int   DIR_ROWS    = 23;
  localparam int   Q_SLOTS     = 8;
  localparam int   BEEP_MS     = 45;
  localparam int   CYCLE_LIMIT = 200000;
  localparam res_t QUIET       = '0;
  localparam res_t STEADY_2200 = '{1'b0, 1'b0, DEFAULT_FREQ, 1'b1};
  localparam res_t CHIRP_START = '{1'b0, 1'b1, HZ_C7, 1'b1};

  typedef struct packed {
    logic [15:0] hz;
    logic [6:0]  ms;
  } note_t;

  typedef struct packed {
    logic        wr_cfg;
    logic        cfg_val;
    mode_t       mode;
    logic [2:0]  code;
    logic [16:0] iv;
    logic [15:0] fq;
    logic        typed;
    res_t        want;
  } dir_row_t;

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        s_tvalid  = 1'b0;
  logic        s_tready;
  logic [39:0] s_tdata   = '0;
  logic [1:0]  s_tuser   = '0;
  logic        m_tvalid;
  logic        m_tready  = 1'b0;
  logic [23:0] m_tdata;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_data  = 1'b0;

  logic        row_typed = 1'b0;
  res_t        row_want  = '0;
  bit          calm      = 1'b0;
  int          errors    = 0;
  int          cycles    = 0;
  int          n_ticks   = 0;
  int          n_events  = 0;
  int          n_drops   = 0;
  int          n_prox    = 0;
  int          n_checked = 0;
  int          n_tone    = 0;

  dir_row_t    plan [DIR_ROWS];

  // predictor state
  bit          sound_on   = 1'b1;
  logic [2:0]  ev_fifo [Q_SLOTS];
  int          fifo_head  = 0;
  int          fifo_count = 0;
  bit          tune_on    = 1'b0;
  logic [2:0]  tune_code  = '0;
  int          tune_idx   = 0;
  int          note_left  = 0;
  bit          cad_on     = 1'b0;
  int          beep_left  = 0;
  int          gap_left   = 0;
  int          cad_iv     = -1;
  logic [15:0] cad_hz     = DEFAULT_FREQ;
  logic [15:0] tone_now   = '0;
  res_t        outcome_q [$];

  buzzer_jingle_and_cadence_sequencer #(
    .QUEUE_DEPTH    (Q_SLOTS),
    .BEEP_LENGTH_MS (BEEP_MS)
  ) uut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always #1 clk = ~clk;

  function automatic note_t tune_note(input logic [2:0] code, input int idx);
    note_t seq [5];
    case (code)
      3'd0: seq = '{{HZ_G6, 7'd60}, {16'd0, 7'd40}, {HZ_C7, 7'd100}, '0, '0};
      3'd1: seq = '{{HZ_C7, 7'd25}, '0, '0, '0, '0};
      3'd2: seq = '{{HZ_C7, 7'd25}, {16'd0, 7'd35}, {HZ_C7, 7'd25}, '0, '0};
      3'd3: seq = '{{HZ_E6, 7'd50}, {16'd0, 7'd25}, {HZ_A6, 7'd70}, '0, '0};
      3'd4: seq = '{{HZ_A6, 7'd50}, {16'd0, 7'd25}, {HZ_E6, 7'd70}, '0, '0};
      3'd5: seq = '{{HZ_A6, 7'd45}, {16'd0, 7'd20}, {HZ_CS7, 7'd45}, {16'd0, 7'd20},
                    {HZ_E7, 7'd80}};
      3'd6: seq = '{{HZ_B6, 7'd60}, {16'd0, 7'd25}, {HZ_E6, 7'd90}, '0, '0};
      default: seq = '{'0, '0, '0, '0, '0};
    endcase
    return seq[idx % 5];
  endfunction

  function automatic int tune_len(input logic [2:0] code);
    case (code)
      3'd1:    return 1;
      3'd5:    return 5;
      EV_SILENT: return 0;
      default: return 3;
    endcase
  endfunction

  task automatic load_note();
    note_t nt;
    nt = tune_note(tune_code, tune_idx);
    note_left = nt.ms;
    if (nt.hz != 0) tone_now = nt.hz;
  endtask

  task automatic ms_tick();
    logic [2:0] code;
    int n;
    if (tune_on) begin
      if (note_left > 0) note_left--;
      if (note_left > 0) return;
      tune_idx++;
      if (tune_idx < tune_len(tune_code)) begin
        load_note();
        return;
      end
      tune_on = 1'b0;
      tune_idx = 0;
      cad_on = 1'b0;
      gap_left = 0;
    end
    for (n = 0; n < Q_SLOTS && fifo_count > 0; n++) begin
      code = ev_fifo[fifo_head];
      fifo_head = (fifo_head + 1) % Q_SLOTS;
      fifo_count--;
      cad_on = 1'b0;
      gap_left = 0;
      if (sound_on && tune_len(code) > 0) begin
        tune_on = 1'b1;
        tune_code = code;
        tune_idx = 0;
        load_note();
        return;
      end
    end
    if (beep_left > 0) beep_left--;
    if (gap_left > 0) gap_left--;
    if (!sound_on || cad_iv < 0) begin
      cad_on = 1'b0;
    end else if (cad_iv == 0) begin
      if (!cad_on) begin
        cad_on = 1'b1;
        tone_now = cad_hz;
      end
    end else begin
      if (cad_on && beep_left == 0) cad_on = 1'b0;
      if (!cad_on && gap_left == 0) begin
        cad_on = 1'b1;
        tone_now = cad_hz;
        beep_left = BEEP_MS;
        gap_left = cad_iv & 16'hFFFF;
      end
    end
  endtask

  task automatic apply_item(input mode_t mode, input logic [2:0] code, input logic [16:0] iv,
                            input logic [15:0] fq, output res_t r);
    note_t nt;
    bit lit;
    r = QUIET;
    case (mode)
      MODE_TICK: ms_tick();
      MODE_EVENT: begin
        if (fifo_count < Q_SLOTS) begin
          ev_fifo[(fifo_head + fifo_count) % Q_SLOTS] = code;
          fifo_count++;
        end else begin
          r.event_dropped = 1'b1;
        end
      end
      MODE_PROX: begin
        if (fq != 0) cad_hz = fq;
        cad_iv = $signed(iv);
      end
      default: ;
    endcase
    nt = tune_note(tune_code, tune_idx);
    lit = tune_on ? (nt.hz != 0) : cad_on;
    r.tone_active = lit;
    r.tone_hz = lit ? tone_now : 16'd0;
    r.jingle_busy = tune_on;
  endtask

  task automatic mismatch(input string what, input logic [15:0] want, input logic [15:0] got);
    $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
    errors++;
  endtask

  always @(posedge clk) begin
    res_t calc;
    res_t want;
    res_t got;
    if (!rst) begin
      if (cfg_valid && cfg_ready) sound_on = cfg_data;
      if (s_tvalid && s_tready) begin
        apply_item(mode_t'(s_tuser), s_tdata[2:0], s_tdata[19:3], s_tdata[35:20], calc);
        outcome_q.push_back(row_typed ? row_want : calc);
        case (mode_t'(s_tuser))
          MODE_TICK:  n_ticks++;
          MODE_EVENT: n_events++;
          MODE_PROX:  n_prox++;
          default: ;
        endcase
        if (calc.event_dropped) n_drops++;
      end
      if (m_tvalid && m_tready) begin
        got = res_t'(m_tdata[18:0]);
        if (outcome_q.size() == 0) begin
          $display("%0t: result with nothing expected, got %h", $time, got);
          errors++;
        end else begin
          want = outcome_q.pop_front();
          n_checked++;
          if (got.tone_active === 1'b1) n_tone++;
          if (got.tone_active !== want.tone_active)
            mismatch("tone_active", 16'(want.tone_active), 16'(got.tone_active));
          if (got.tone_hz !== want.tone_hz)
            mismatch("tone_hz", want.tone_hz, got.tone_hz);
          if (got.jingle_busy !== want.jingle_busy)
            mismatch("jingle_busy", 16'(want.jingle_busy), 16'(got.jingle_busy));
          if (got.event_dropped !== want.event_dropped)
            mismatch("event_dropped", 16'(want.event_dropped), 16'(got.event_dropped));
        end
      end
    end
  end

  always @(posedge clk) m_tready <= calm || ($urandom_range(99) >= 12);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic send(input mode_t mode, input logic [2:0] code, input logic [16:0] iv,
                      input logic [15:0] fq, input logic typed, input res_t want);
    while (!calm && $urandom_range(99) < 12) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid  <= 1'b1;
    s_tuser   <= mode;
    s_tdata   <= {4'd0, fq, iv, code};
    row_typed <= typed;
    row_want  <= want;
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (outcome_q.size() != 0);
  endtask

  task automatic set_enable(input logic en);
    drain();
    cfg_valid <= 1'b1;
    cfg_data  <= en;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [16:0] pick_interval();
    int r;
    r = $urandom_range(99);
    if (r < 20) return 17'd0;
    if (r < 35) return '1;
    if (r < 85) return 17'($urandom_range(80, 1));
    if (r < 95) return 17'($urandom_range(400, 81));
    return 17'($urandom_range(65535));
  endfunction

  function automatic logic [15:0] pick_freq();
    if ($urandom_range(99) < 25) return 16'd0;
    return 16'($urandom_range(65535, 1));
  endfunction

  function automatic logic [2:0] pick_code();
    int r;
    r = $urandom_range(99);
    if (r < 40) return 3'd1;
    if (r < 55) return EV_SILENT;
    return 3'($urandom_range(7));
  endfunction

  initial begin
    int r;
    int done;
    plan = '{
      '{1'b1, 1'b1, MODE_TICK,  3'd0, 17'd0,     16'd0,    1'b1, QUIET},
      '{1'b0, 1'b0, MODE_NONE,  3'd7, 17'h1FFFF, 16'hFFFF, 1'b1, QUIET},
      '{1'b0, 1'b0, MODE_PROX,  3'd0, 17'd0,     16'd0,    1'b1, QUIET},
      '{1'b0, 1'b0, MODE_TICK,  3'd0, 17'd0,     16'd0,    1'b1, STEADY_2200},
      '{1'b0, 1'b0, MODE_PROX,  3'd0, 17'd40,    16'hFFFF, 1'b0, QUIET},
      '{1'b0, 1'b0, MODE_TICK,  3'd0, 17'd0,     16'd0,    1'b0, QUIET},
      '{1'b0, 1'b0, MODE_TICK,  3'd0, 17'd0,     16'd0,    1'b0, QUIET},
      '{1'b0, 1'b0, MODE_PROX,  3'd0, 17'h1FFFF, 16'd1,    1'b0, QUIET},
      '{1'b0, 1'b0, MODE_TICK,  3'd0, 17'd0,     16'd0,    1'b1, QUIET},
      '{1'b0, 1'b0, MODE_PROX,  3'd0, 17'h0FFFF, 16'd0,    1'b1, QUIET},
      '{1'b0, 1'b0, MODE_TICK,  3'd0, 17'd0,     16'd0,    1'b0, QUIET},
      '{1'b0, 1'b0, MODE_EVENT, 3'd1, 17'd0,     16'd0,    1'b0, QUIET},
      '{1'b0, 1'b0, MODE_TICK,  3'd0, 17'd0,     16'd0,    1'b1, CHIRP_START},
      '{1'b1, 1'b0, MODE_EVENT, 3'd0, 17'd0,     16'd0,    1'b0, QUIET},
      '{1'b0, 1'b0, MODE_EVENT, 3'd1, 17'd0,     16'd0,    1'b0, QUIET},
      '{1'b0, 1'b0, MODE_EVENT, 3'd2, 17'd0,     16'd0,    1'b0, QUIET},
      '{1'b0, 1'b0, MODE_EVENT, 3'd3, 17'd0,     16'd0,    1'b0, QUIET},
      '{1'b0, 1'b0, MODE_EVENT, 3'd4, 17'd0,     16'd0,    1'b0, QUIET},
      '{1'b0, 1'b0, MODE_EVENT, 3'd5, 17'd0,     16'd0,    1'b0, QUIET},
      '{1'b0, 1'b0, MODE_EVENT, 3'd6, 17'd0,     16'd0,    1'b0, QUIET},
      '{1'b0, 1'b0, MODE_EVENT, 3'd7, 17'd0,     16'd0,    1'b0, QUIET},
      '{1'b0, 1'b0, MODE_EVENT, 3'd3, 17'd0,     16'd0,    1'b0, QUIET},
      '{1'b0, 1'b0, MODE_TICK,  3'd0, 17'd0,     16'd0,    1'b0, QUIET}
    };
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      if (plan[i].wr_cfg) set_enable(plan[i].cfg_val);
      send(plan[i].mode, plan[i].code, plan[i].iv, plan[i].fq, plan[i].typed, plan[i].want);
    end

    for (int p = 0; p < PHASES; p++) begin
      set_enable(1'(p % 2));
      calm = (p == 3);
      done = 0;
      while (done < PHASE_ITEMS) begin
        r = $urandom_range(99);
        if (p % 2 == 0 && r < 3) begin
          // flood the queue while muted
          repeat (10) send(MODE_EVENT, pick_code(), pick_interval(), pick_freq(), 1'b0, QUIET);
          done += 10;
        end else if (r < 7) begin
          send(MODE_EVENT, pick_code(), pick_interval(), pick_freq(), 1'b0, QUIET);
          done++;
        end else if (r < 19) begin
          send(MODE_PROX, pick_code(), pick_interval(), pick_freq(), 1'b0, QUIET);
          done++;
        end else if (r < 23) begin
          send(MODE_NONE, pick_code(), pick_interval(), pick_freq(), 1'b0, QUIET);
        end else if (r < 24) begin
          drain();
        end else begin
          send(MODE_TICK, pick_code(), pick_interval(), pick_freq(), 1'b0, QUIET);
          done++;
        end
      end
    end

    drain();
    repeat (4) @(posedge clk);
    $display("run: %0d ticks, %0d events (%0d dropped), %0d proximity updates",
             n_ticks, n_events, n_drops, n_prox);
    $display("run: %0d results checked, %0d with tone on, %0d mismatches",
             n_checked, n_tone, errors);
    if (errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule

>>> sim.f
sv/bjcs_pkg.sv
sv/bjcs_queue.sv
sv/bjcs_core.sv
sv/bjcs_skid.sv
sv/buzzer_jingle_and_cadence_sequencer.sv
test/tb_top.sv
